// ----- design/gke_pkg.sv -----
// Shared types and constants for the Gaussian kernel evaluator.
// No dependencies; every other design file imports this package.
package gke_pkg;

   localparam logic [2:0] CSR_MODE       = 3'd0;
   localparam logic [2:0] CSR_AMPLITUDE  = 3'd1;
   localparam logic [2:0] CSR_INV_RHO_SQ = 3'd2;
   localparam logic [2:0] CSR_COEF_XX    = 3'd3;
   localparam logic [2:0] CSR_COEF_XY    = 3'd4;
   localparam logic [2:0] CSR_COEF_YY    = 3'd5;

   localparam logic [47:0]  EXP_CAP     = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0]  ONE_Q16     = 32'h0001_0000;
   localparam logic [63:0]  ONE_Q62     = 64'h4000_0000_0000_0000;
   localparam logic [127:0] HALF_Q62    = 128'h2000_0000_0000_0000;
   localparam logic [4:0]   SERIES_LAST = 5'd24;
   localparam logic [31:0]  EXP_LIMIT   = 32'd40;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;

   typedef enum logic [1:0] {DIM_FIRST, DIM_SECOND, DIM_REST} dim_class_type;

   typedef struct packed {
      logic signed [32:0] diff;
      logic               last;
      logic               mode;
      dim_class_type      dim;
   } item_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] amplitude;
      logic [31:0] inv_rho_sq;
      logic [31:0] coef_xx;
      logic [31:0] coef_xy;
      logic [31:0] coef_yy;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [47:0] x;
   } exp_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } exp_rsp_type;

   typedef enum logic [3:0] {
      B_IDLE, B_START, B_MUL0, B_MUL1, B_MUL2, B_TERM, B_COMB, B_ACC, B_EXP, B_OUT
   } back_state_type;

   typedef enum logic [2:0] {X_IDLE, X_MUL, X_POST, X_DIV, X_SER} exp_state_type;

   typedef enum logic [1:0] {PH_E1, PH_FRAC, PH_POW, PH_FIN} exp_phase_type;

endpackage

// ----- design/gke_queue.sv -----
// Two-entry request queue between the front and back parts.
// Depends on gke_pkg.
module gke_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              pop,
   input  gke_pkg::item_type wr_item,
   output gke_pkg::item_type rd_item,
   output logic              full,
   output logic              empty
);
   import gke_pkg::*;

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_item = mem_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? wp_ff + QPTR_W'(1) : wp_ff;
      rp_in  = do_pop ? rp_ff + QPTR_W'(1) : rp_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= wr_item;
      end
   end

endmodule

// ----- design/gke_front.sv -----
// Front part: accepts requests, forms the centre difference, tags the dimension.
// Depends on gke_pkg.
module gke_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic signed [31:0] coordinate,
   input  logic signed [31:0] centre,
   input  logic               last_dim,
   input  logic               mode,
   input  logic               q_full,
   output logic               full,
   output logic               q_push,
   output gke_pkg::item_type  q_item
);
   import gke_pkg::*;

   logic [1:0]         dim_ff, dim_in;
   logic signed [32:0] diff;

   assign diff   = 33'(coordinate) - 33'(centre);
   assign full   = q_full;
   assign q_push = push && !q_full;

   always_comb begin
      q_item.diff = diff;
      q_item.last = last_dim;
      q_item.mode = mode;
      priority if (dim_ff == 2'd0) begin
         q_item.dim = DIM_FIRST;
      end else if (dim_ff == 2'd1) begin
         q_item.dim = DIM_SECOND;
      end else begin
         q_item.dim = DIM_REST;
      end
   end

   always_comb begin
      dim_in = dim_ff;
      if (q_push) begin
         if (last_dim) begin
            dim_in = 2'd0;
         end else if (dim_ff != 2'd2) begin
            dim_in = dim_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= 2'd0;
      end else begin
         dim_ff <= dim_in;
      end
   end

endmodule

// ----- design/gke_exp.sv -----
// Exponential unit: amplitude * exp(-x) by a series to the 24th-order term, integer powers of e^-1
// and a final rounded product; one shared 64x64 multiplier built of 32x32 partials.
// Depends on gke_pkg.
module gke_exp (
   input  logic                 clock,
   input  logic                 reset,
   input  gke_pkg::exp_req_type req,
   input  logic [31:0]          amplitude,
   output gke_pkg::exp_rsp_type rsp
);
   import gke_pkg::*;

   exp_state_type state_ff, state_in;
   exp_phase_type phase_ff, phase_in;
   logic [63:0]   ma_ff, ma_in, mb_ff, mb_in, pp_ff, pp_in, f_ff, f_in;
   logic [63:0]   acc_ff, acc_in, e1_ff, e1_in, q_ff, q_in;
   logic [127:0]  prod_ff, prod_in;
   logic [2:0]    mc_ff, mc_in;
   logic [4:0]    k_ff, k_in, r_ff, r_in;
   logic [3:0]    dc_ff, dc_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [15:0]   frac_ff, frac_in;
   logic [31:0]   value_ff, value_in;

   logic [31:0]   amag, pa, pb, n_int;
   logic [63:0]   amag64, p, sum_next, f_frac, qv;
   logic [127:0]  addend, prod_rnd;
   logic [2:0]    add_idx;
   logic [4:0]    rv;
   logic [5:0]    rt;
   logic          big;

   assign amag   = amplitude[31] ? (~amplitude + 32'd1) : amplitude;
   assign amag64 = 64'(amag);
   assign n_int  = req.x[47:16];
   assign big    = n_int > EXP_LIMIT;
   assign f_frac = {2'b00, frac_ff, 46'd0};

   always_comb begin
      unique case (mc_ff[1:0])
         2'd0:    begin pa = ma_ff[31:0];  pb = mb_ff[31:0];  end
         2'd1:    begin pa = ma_ff[31:0];  pb = mb_ff[63:32]; end
         2'd2:    begin pa = ma_ff[63:32]; pb = mb_ff[31:0];  end
         default: begin pa = ma_ff[63:32]; pb = mb_ff[63:32]; end
      endcase
      add_idx = mc_ff - 3'd1;
      unique case (add_idx[1:0])
         2'd0:    addend = {64'd0, pp_ff};
         2'd3:    addend = {pp_ff, 64'd0};
         default: addend = {32'd0, pp_ff, 32'd0};
      endcase
      prod_rnd = prod_ff + ((phase_ff == PH_FIN) ? HALF_Q62 : 128'd0);
      p        = prod_rnd[125:62];
      sum_next = k_ff[0] ? acc_ff - q_ff : acc_ff + q_ff;
   end

   // four restoring steps of division by the small series index
   always_comb begin
      qv = q_ff;
      rv = r_ff;
      rt = '0;
      for (int j = 0; j < 4; j++) begin
         rt = {rv, qv[63]};
         qv = {qv[62:0], 1'b0};
         if (rt >= {1'b0, k_ff}) begin
            rt    = rt - {1'b0, k_ff};
            qv[0] = 1'b1;
         end
         rv = rt[4:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         X_IDLE: if (req.start) state_in = X_MUL;
         X_MUL:  if (mc_ff == 3'd4) state_in = X_POST;
         X_POST: begin
            unique case (phase_ff)
               PH_FIN:           state_in = X_IDLE;
               PH_POW:           state_in = X_MUL;
               PH_E1, PH_FRAC:   state_in = X_DIV;
            endcase
         end
         X_DIV:  if (dc_ff == 4'd15) state_in = X_SER;
         X_SER:  state_in = X_MUL;
         default: state_in = X_IDLE;
      endcase
   end

   always_comb begin
      rsp.done  = (state_ff == X_POST) && (phase_ff == PH_FIN);
      rsp.value = value_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      pp_in    = pp_ff;
      prod_in  = prod_ff;
      mc_in    = mc_ff;
      f_in     = f_ff;
      acc_in   = acc_ff;
      e1_in    = e1_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      dc_in    = dc_ff;
      cnt_in   = cnt_ff;
      frac_in  = frac_ff;
      value_in = value_ff;
      unique case (state_ff)
         X_IDLE: begin
            if (req.start) begin
               cnt_in  = n_int[5:0];
               frac_in = req.x[15:0];
               prod_in = '0;
               mc_in   = '0;
               if (big) begin
                  phase_in = PH_FIN;
                  ma_in    = amag64;
                  mb_in    = '0;
               end else begin
                  phase_in = PH_E1;
                  ma_in    = ONE_Q62;
                  mb_in    = ONE_Q62;
                  f_in     = ONE_Q62;
                  acc_in   = ONE_Q62;
                  k_in     = 5'd1;
               end
            end
         end
         X_MUL: begin
            mc_in = mc_ff + 3'd1;
            if (mc_ff != 3'd4) pp_in = 64'(pa) * 64'(pb);
            if (mc_ff != 3'd0) prod_in = prod_ff + addend;
         end
         X_POST: begin
            unique case (phase_ff)
               PH_FIN: begin
                  value_in = amplitude[31] ? (~p[31:0] + 32'd1) : p[31:0];
               end
               PH_POW: begin
                  acc_in  = p;
                  cnt_in  = cnt_ff - 6'd1;
                  prod_in = '0;
                  mc_in   = '0;
                  if (cnt_ff == 6'd1) begin
                     phase_in = PH_FIN;
                     ma_in    = amag64;
                     mb_in    = p;
                  end else begin
                     ma_in = p;
                     mb_in = e1_ff;
                  end
               end
               PH_E1, PH_FRAC: begin
                  q_in  = p;
                  r_in  = '0;
                  dc_in = '0;
               end
            endcase
         end
         X_DIV: begin
            q_in  = qv;
            r_in  = rv;
            dc_in = dc_ff + 4'd1;
         end
         X_SER: begin
            prod_in = '0;
            mc_in   = '0;
            acc_in  = sum_next;
            if (k_ff == SERIES_LAST) begin
               if (phase_ff == PH_E1) begin
                  e1_in    = sum_next;
                  phase_in = PH_FRAC;
                  f_in     = f_frac;
                  acc_in   = ONE_Q62;
                  k_in     = 5'd1;
                  ma_in    = ONE_Q62;
                  mb_in    = f_frac;
               end else if (cnt_ff == 6'd0) begin
                  phase_in = PH_FIN;
                  ma_in    = amag64;
                  mb_in    = sum_next;
               end else begin
                  phase_in = PH_POW;
                  ma_in    = sum_next;
                  mb_in    = e1_ff;
               end
            end else begin
               k_in  = k_ff + 5'd1;
               ma_in = q_ff;
               mb_in = f_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= X_IDLE;
         phase_ff <= PH_E1;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      pp_ff    <= pp_in;
      prod_ff  <= prod_in;
      mc_ff    <= mc_in;
      f_ff     <= f_in;
      acc_ff   <= acc_in;
      e1_ff    <= e1_in;
      q_ff     <= q_in;
      k_ff     <= k_in;
      r_ff     <= r_in;
      dc_ff    <= dc_in;
      cnt_ff   <= cnt_in;
      frac_ff  <= frac_in;
      value_ff <= value_in;
   end

endmodule

// ----- design/gke_back.sv -----
// Back part: per-dimension quadratic terms on one 32x32 multiplier, exponent
// accumulation, hand-off to the exponential unit and the response register.
// Depends on gke_pkg.
module gke_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  gke_pkg::item_type    q_item,
   output logic                 q_pop,
   input  gke_pkg::cfg_type     cfg,
   output gke_pkg::exp_req_type exp_req,
   input  gke_pkg::exp_rsp_type exp_rsp,
   output logic                 empty,
   input  logic                 pop,
   output logic [31:0]          result_value
);
   import gke_pkg::*;

   back_state_type     state_ff, state_in;
   item_type           item_ff, item_in;
   logic signed [32:0] fd_ff, fd_in;
   logic [1:0]         tix_ff, tix_in, nterm;
   logic [63:0]        p_ff, p_in, m1_ff, m1_in, m2_ff, m2_in;
   logic [47:0]        t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   logic [47:0]        tsum_ff, tsum_in, esum_ff, esum_in;
   logic [31:0]        res_ff, res_in;
   logic               rvalid_ff, rvalid_in;

   logic [31:0]        dm, m0, bmag, opx, opy, opw;
   logic [64:0]        tsat_sum;
   logic [47:0]        tnew, tsum_new, esum_sat;
   logic [48:0]        pos, esum_sum;
   logic [49:0]        pos2;
   logic               neg, rot2, load_res;

   assign dm   = item_ff.diff[32] ? 32'(-item_ff.diff) : item_ff.diff[31:0];
   assign m0   = fd_ff[32] ? 32'(-fd_ff) : fd_ff[31:0];
   assign bmag = cfg.coef_xy[31] ? (~cfg.coef_xy + 32'd1) : cfg.coef_xy;
   assign rot2 = item_ff.mode && (item_ff.dim == DIM_SECOND);

   always_comb begin
      if (rot2) begin
         nterm = 2'd3;
      end else if (item_ff.dim == DIM_FIRST && item_ff.mode && !item_ff.last) begin
         nterm = 2'd0;
      end else begin
         nterm = 2'd1;
      end
      if (rot2) begin
         unique case (tix_ff)
            2'd0:    begin opx = m0; opy = m0; opw = cfg.coef_xx; end
            2'd1:    begin opx = dm; opy = dm; opw = cfg.coef_yy; end
            default: begin opx = m0; opy = dm; opw = bmag;        end
         endcase
      end else begin
         opx = dm;
         opy = dm;
         if (item_ff.dim == DIM_FIRST && item_ff.mode) begin
            opw = cfg.coef_xx;
         end else if (item_ff.dim == DIM_SECOND && !item_ff.mode) begin
            opw = cfg.inv_rho_sq;
         end else begin
            opw = ONE_Q16;
         end
      end
   end

   always_comb begin
      tsat_sum = 65'(m2_ff) + 65'(m1_ff[63:32]);
      tnew     = (|tsat_sum[64:48]) ? EXP_CAP : tsat_sum[47:0];
      pos      = 49'(t0_ff) + 49'(t1_ff);
      neg      = ((fd_ff[32] != item_ff.diff[32]) != cfg.coef_xy[31]) && (t2_ff != '0);
      if (!neg) begin
         pos2 = 50'(pos) + 50'(t2_ff);
      end else if (49'(t2_ff) > pos) begin
         pos2 = '0;
      end else begin
         pos2 = 50'(pos - 49'(t2_ff));
      end
      if (rot2) begin
         tsum_new = (|pos2[49:48]) ? EXP_CAP : pos2[47:0];
      end else if (nterm == 2'd0) begin
         tsum_new = '0;
      end else begin
         tsum_new = t0_ff;
      end
      esum_sum = 49'(esum_ff) + 49'(tsum_ff);
      esum_sat = esum_sum[48] ? EXP_CAP : esum_sum[47:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!q_empty) state_in = B_START;
         B_START: state_in = (nterm == 2'd0) ? B_COMB : B_MUL0;
         B_MUL0:  state_in = B_MUL1;
         B_MUL1:  state_in = B_MUL2;
         B_MUL2:  state_in = B_TERM;
         B_TERM:  state_in = (tix_ff == nterm - 2'd1) ? B_COMB : B_MUL0;
         B_COMB:  state_in = B_ACC;
         B_ACC:   state_in = item_ff.last ? B_EXP : B_IDLE;
         B_EXP:   if (exp_rsp.done) state_in = B_OUT;
         B_OUT:   if (!rvalid_ff) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = (state_ff == B_IDLE) && !q_empty;
      exp_req.start = (state_ff == B_ACC) && item_ff.last;
      exp_req.x     = esum_sat;
      load_res      = (state_ff == B_OUT) && !rvalid_ff;
   end

   always_comb begin
      item_in = item_ff;
      fd_in   = fd_ff;
      tix_in  = tix_ff;
      p_in    = p_ff;
      m1_in   = m1_ff;
      m2_in   = m2_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      t2_in   = t2_ff;
      tsum_in = tsum_ff;
      esum_in = esum_ff;
      res_in  = load_res ? exp_rsp.value : res_ff;
      rvalid_in = (rvalid_ff && !pop) || load_res;
      unique case (state_ff)
         B_IDLE: begin
            if (q_pop) item_in = q_item;
            tix_in = '0;
         end
         B_START: if (item_ff.dim == DIM_FIRST) fd_in = item_ff.diff;
         B_MUL0:  p_in  = 64'(opx) * 64'(opy);
         B_MUL1:  m1_in = 64'(p_ff[31:0]) * 64'(opw);
         B_MUL2:  m2_in = 64'(p_ff[63:32]) * 64'(opw);
         B_TERM: begin
            unique case (tix_ff)
               2'd0:    t0_in = tnew;
               2'd1:    t1_in = tnew;
               default: t2_in = tnew;
            endcase
            tix_in = tix_ff + 2'd1;
         end
         B_COMB: tsum_in = tsum_new;
         B_ACC: begin
            if (item_ff.last) begin
               esum_in = '0;
               fd_in   = '0;
            end else begin
               esum_in = esum_sat;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         rvalid_ff <= 1'b0;
         esum_ff   <= '0;
         fd_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         esum_ff   <= esum_in;
         fd_ff     <= fd_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      tix_ff  <= tix_in;
      p_ff    <= p_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      tsum_ff <= tsum_in;
      res_ff  <= res_in;
   end

   assign empty        = !rvalid_ff;
   assign result_value = res_ff;

endmodule

// ----- design/gaussian_kernel_evaluator_unit.sv -----
// Gaussian kernel evaluator top level: CSR bank, front, request queue, back, exp unit.
// Back part: each term runs MUL0, MUL1, MUL2, TERM; a request has none, one or, for the rotated
// 2nd dim, three. A final request then runs the exp unit: e^-1 and e^-frac series and a product
// per integer unit of exponent (all skipped at an exponent of 41 or more), then a final product.
// Throughput is set by the back part; the front takes one request per cycle while the two-entry
// queue is not full. Synchronous active-high reset restores CSR defaults and empties every stage.
module gaussian_kernel_evaluator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [31:0] req_coordinate,
   input  logic signed [31:0] req_centre,
   input  logic               req_last_dim,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_result_value,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);
   import gke_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   item_type    f_item, q_rd_item;
   logic        q_push, q_pop, q_full, q_empty;
   exp_req_type exp_req;
   exp_rsp_type exp_rsp;
   logic [31:0] result_value;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:       cfg_in.mode       = csr_wr_data[0];
            CSR_AMPLITUDE:  cfg_in.amplitude  = csr_wr_data;
            CSR_INV_RHO_SQ: cfg_in.inv_rho_sq = csr_wr_data;
            CSR_COEF_XX:    cfg_in.coef_xx    = csr_wr_data;
            CSR_COEF_XY:    cfg_in.coef_xy    = csr_wr_data;
            CSR_COEF_YY:    cfg_in.coef_yy    = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= 1'b0;
         cfg_ff.amplitude  <= ONE_Q16;
         cfg_ff.inv_rho_sq <= ONE_Q16;
         cfg_ff.coef_xx    <= ONE_Q16;
         cfg_ff.coef_xy    <= '0;
         cfg_ff.coef_yy    <= ONE_Q16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gke_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .coordinate (req_coordinate),
      .centre     (req_centre),
      .last_dim   (req_last_dim),
      .mode       (cfg_ff.mode),
      .q_full     (q_full),
      .full       (full),
      .q_push     (q_push),
      .q_item     (f_item)
   );

   gke_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .pop     (q_pop),
      .wr_item (f_item),
      .rd_item (q_rd_item),
      .full    (q_full),
      .empty   (q_empty)
   );

   gke_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_item       (q_rd_item),
      .q_pop        (q_pop),
      .cfg          (cfg_ff),
      .exp_req      (exp_req),
      .exp_rsp      (exp_rsp),
      .empty        (empty),
      .pop          (pop),
      .result_value (result_value)
   );

   gke_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .req       (exp_req),
      .amplitude (cfg_ff.amplitude),
      .rsp       (exp_rsp)
   );

   assign rsp_result_value = result_value;

endmodule
